// ----- hdl/rgbd_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and mask tables for the rgb to irgb ordered dither block
// used by every module of the block; depends on nothing

package rgbd_pkg;

    // channel and field widths
    localparam int CHAN_W    = 8;
    localparam int POS_W     = 12;
    localparam int MAPW_W    = 13;
    localparam int ADDR_W    = 23;
    localparam int PROD_W    = MAPW_W + POS_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int DIV_W     = CHAN_W + 1;
    localparam int QUO_W     = 4;
    localparam int PAT_W     = 16;
    localparam int NCHAN     = 3;

    // pipeline shape: one front stage, one stage per quotient bit, one output stage
    localparam int DIV_STAGES = QUO_W;
    localparam int NSTG       = DIV_STAGES + 2;

    // stream and register port widths
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 104;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register select on paddr[2]
    localparam logic REG_MAP_WIDTH = 1'b0;
    localparam logic REG_DITHER_EN = 1'b1;

    // reset values of the registers
    localparam logic [MAPW_W-1:0] MAP_WIDTH_RST = 13'd320;
    localparam logic              DITHER_EN_RST = 1'b1;

    // fixed 4x4 ramp of dither masks, sparse to dense
    localparam logic [PAT_W-1:0] RAMP [16] = '{
        16'h0000, 16'h8000, 16'h8020, 16'h80A0, 16'hA0A0, 16'hA4A0, 16'hA4A1, 16'hA4A5,
        16'hA5A5, 16'hADA5, 16'hADA7, 16'hADAF, 16'hAFAF, 16'hEFAF, 16'hEFBF, 16'hEFFF
    };

    // conversion case chosen from the brightest channel
    typedef enum logic [1:0] {
        KIND_BRIGHT,
        KIND_LGREY,
        KIND_DGREY,
        KIND_COLOR
    } kind_t;

    // payload that travels down the division stages
    typedef struct packed {
        kind_t                         kind;
        logic [CHAN_W-1:0]             mx;
        logic [DIV_W-1:0]              divisor;
        logic [NCHAN-1:0][DIV_W-1:0]   rem;
        logic [NCHAN-1:0][QUO_W-1:0]   quo;
        logic [NCHAN-1:0][QUO_W-1:0]   col_idx;
        logic [3:0]                    clr;
        logic [1:0]                    xq;
        logic [1:0]                    yq;
        logic [ACC_W-1:0]              acc;
    } pipe_t;

    // one result item
    typedef struct packed {
        logic [PAT_W-1:0]  blue_pattern;
        logic [PAT_W-1:0]  green_pattern;
        logic [PAT_W-1:0]  red_pattern;
        logic [PAT_W-1:0]  bright_pattern;
        logic [3:0]        color_index;
        logic [7:0]        or_byte;
        logic [ADDR_W-1:0] byte_address;
    } result_t;

    function automatic logic [PAT_W-1:0] dark_mask(input logic [3:0] idx);
        return RAMP[idx];
    endfunction

    // bright ramp tops out fully set
    function automatic logic [PAT_W-1:0] bright_mask(input logic [3:0] idx);
        return (idx == 4'hF) ? {PAT_W{1'b1}} : RAMP[idx];
    endfunction

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                 input logic [DIV_W-1:0] divisor);
        logic [DIV_W:0] shifted;
        logic [DIV_W:0] diff;
        shifted = {rem, 1'b0};
        diff    = shifted - {1'b0, divisor};
        if (shifted >= {1'b0, divisor}) begin
            return {1'b1, diff[DIV_W-1:0]};
        end else begin
            return {1'b0, shifted[DIV_W-1:0]};
        end
    endfunction

endpackage

// ----- hdl/rgb_to_irgb_ordered_dither.sv -----
`timescale 1ns / 1ps
// top level of the rgb to irgb ordered dither converter
// depends on rgbd_pkg and rgbd_mask_sel
//
// Converts one pixel (x, y, red, green, blue) to a 4-bit IRGB code.
// Input stream s_*: one transfer per pixel, tdata = {blue, green, red, y_pos, x_pos}.
// Output stream m_*: one transfer per pixel, in order, carrying the packed map
// byte address, the nibble to OR into that byte, the solid color and the four
// 4x4 dither masks.
// APB port: map_width at 0x0, dither_enable at 0x4; write only while idle.
// Stages: one front stage for max, case split and address product, four stages
// of a restoring divider that produce one quotient bit each, one output register.
// Throughput: one pixel per clock while the output is not stalled; every stage
// is a registered slot with its own valid bit.
// Stall: a slot holds its item while the one after it is full and not moving;
// bubbles close up, so s_tready drops only when all six slots are full.
// Reset: aresetn clears every valid bit and reloads map_width = 320 and
// dither_enable = 1.

module rgb_to_irgb_ordered_dither (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [11:0] x_pos, [23:12] y_pos, [31:24] red, [39:32] green, [47:40] blue
    input  logic [rgbd_pkg::S_DATA_W-1:0] s_tdata,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [22:0] byte_address, [30:23] or_byte, [34:31] color_index,
    // [50:35] bright_pattern, [66:51] red_pattern, [82:67] green_pattern,
    // [98:83] blue_pattern, [103:99] zero
    output logic [rgbd_pkg::M_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbd_pkg::APB_AW-1:0]   paddr,
    input  logic [rgbd_pkg::APB_DW-1:0]   pwdata,
    output logic [rgbd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import rgbd_pkg::*;

    logic [MAPW_W-1:0] map_width_reg;
    logic              dither_en_reg;

    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   rdy;
    pipe_t             stg_reg [DIV_STAGES+1];
    pipe_t             stg_next [DIV_STAGES+1];
    result_t           res_reg;
    result_t           res_next;

    logic [POS_W-1:0]  x_in;
    logic [POS_W-1:0]  y_in;
    logic [CHAN_W-1:0] r_in;
    logic [CHAN_W-1:0] g_in;
    logic [CHAN_W-1:0] b_in;
    logic [CHAN_W-1:0] mx;
    logic [9:0]        spread;
    logic              cfg_wr;
    logic [POS_W-1:0]  x_hold;

    // configuration registers
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg <= MAP_WIDTH_RST;
            dither_en_reg <= DITHER_EN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MAP_WIDTH: map_width_reg <= pwdata[MAPW_W-1:0];
                REG_DITHER_EN: dither_en_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAP_WIDTH: prdata = {{(APB_DW-MAPW_W){1'b0}}, map_width_reg};
            REG_DITHER_EN: prdata = {{(APB_DW-1){1'b0}}, dither_en_reg};
            default:       prdata = '0;
        endcase
    end

    // ready chain: a slot moves when empty or when the next slot moves
    assign rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
    genvar gr;
    generate
        for (gr = 0; gr < NSTG-1; gr++) begin : g_rdy
            assign rdy[gr] = !vld_reg[gr] || rdy[gr+1];
        end
    endgenerate
    assign s_tready = rdy[0];

    // input field unpack
    assign x_in = s_tdata[11:0];
    assign y_in = s_tdata[23:12];
    assign r_in = s_tdata[31:24];
    assign g_in = s_tdata[39:32];
    assign b_in = s_tdata[47:40];

    // front stage: brightest channel, case split, solid color, address product
    always_comb begin
        if (r_in >= g_in && r_in >= b_in) begin
            mx = r_in;
        end else if (g_in >= b_in) begin
            mx = g_in;
        end else begin
            mx = b_in;
        end
        spread = {2'b00, mx - r_in} + {2'b00, mx - g_in} + {2'b00, mx - b_in};

        stg_next[0].mx         = mx;
        stg_next[0].divisor    = {1'b0, mx} + 9'd8;
        stg_next[0].rem        = {{1'b0, b_in}, {1'b0, g_in}, {1'b0, r_in}};
        stg_next[0].quo        = '0;
        stg_next[0].col_idx    = {b_in[6:3], g_in[6:3], r_in[6:3]};
        stg_next[0].xq         = x_in[1:0];
        stg_next[0].yq         = y_in[1:0];
        stg_next[0].acc        = {1'b0, PROD_W'(map_width_reg) * PROD_W'(y_in)};

        if (mx[7]) begin
            stg_next[0].kind = KIND_BRIGHT;
            stg_next[0].clr  = {1'b1, r_in[7], g_in[7], b_in[7]};
        end else if (spread < 10'd8) begin
            if (mx[6]) begin
                stg_next[0].kind = KIND_LGREY;
                stg_next[0].clr  = 4'h7;
            end else begin
                stg_next[0].kind = KIND_DGREY;
                stg_next[0].clr  = {mx[5], 3'b000};
            end
        end else begin
            stg_next[0].kind = KIND_COLOR;
            stg_next[0].clr  = {1'b0, r_in[6], g_in[6], b_in[6]};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && s_tvalid) begin
            stg_reg[0] <= stg_next[0];
        end
    end

    // full column held beside the front stage for the address add
    always_ff @(posedge aclk) begin
        if (rdy[0] && s_tvalid) begin
            x_hold <= x_in;
        end
    end

    // divider stages: one quotient bit per stage for each channel
    genvar gk;
    generate
        for (gk = 1; gk <= DIV_STAGES; gk++) begin : g_div
            always_comb begin
                logic [DIV_W:0] step;
                stg_next[gk] = stg_reg[gk-1];
                for (int c = 0; c < NCHAN; c++) begin
                    step = div_step(stg_reg[gk-1].rem[c], stg_reg[gk-1].divisor);
                    stg_next[gk].rem[c] = step[DIV_W-1:0];
                    stg_next[gk].quo[c] = {stg_reg[gk-1].quo[c][QUO_W-2:0], step[DIV_W]};
                end
                // column added to the row product in the first divider stage
                if (gk == 1) begin
                    stg_next[gk].acc = stg_reg[gk-1].acc
                                     + {{(ACC_W-POS_W){1'b0}}, x_hold};
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[gk] && vld_reg[gk-1]) begin
                    stg_reg[gk] <= stg_next[gk];
                end
            end
        end
    endgenerate

    // output stage
    rgbd_mask_sel u_mask_sel (
        .stg_in    (stg_reg[DIV_STAGES]),
        .dither_en (dither_en_reg),
        .res_out   (res_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy[NSTG-1] && vld_reg[NSTG-2]) begin
            res_reg <= res_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {{(M_DATA_W-$bits(result_t)){1'b0}}, res_reg};

endmodule

// ----- hdl/rgbd_mask_sel.sv -----
`timescale 1ns / 1ps
// mask table lookup, 4x4 pixel pick and nibble placement for the last stage
// depends on rgbd_pkg

module rgbd_mask_sel (
    input  rgbd_pkg::pipe_t   stg_in,
    input  logic              dither_en,
    output rgbd_pkg::result_t res_out
);
    import rgbd_pkg::*;

    logic [PAT_W-1:0] pi;
    logic [PAT_W-1:0] pr;
    logic [PAT_W-1:0] pg;
    logic [PAT_W-1:0] pb;
    logic [PAT_W-1:0] grey;
    logic [3:0]       ofst;
    logic [3:0]       pix;

    // masks per conversion case
    always_comb begin
        grey = dark_mask(stg_in.mx[5:2]);
        case (stg_in.kind)
            KIND_BRIGHT: begin
                pi = bright_mask(stg_in.mx[6:3]);
                pr = bright_mask(stg_in.quo[0]);
                pg = bright_mask(stg_in.quo[1]);
                pb = bright_mask(stg_in.quo[2]);
            end
            KIND_LGREY: begin
                pi = ~grey;
                pr = grey;
                pg = grey;
                pb = grey;
            end
            KIND_DGREY: begin
                pi = grey;
                pr = '0;
                pg = '0;
                pb = '0;
            end
            default: begin
                pi = '0;
                pr = dark_mask(stg_in.col_idx[0]);
                pg = dark_mask(stg_in.col_idx[1]);
                pb = dark_mask(stg_in.col_idx[2]);
            end
        endcase
    end

    // pixel from the masks at the 4x4 position, or the solid color
    always_comb begin
        ofst = {stg_in.yq, stg_in.xq};
        if (dither_en) begin
            pix = {pi[ofst], pr[ofst], pg[ofst], pb[ofst]};
        end else begin
            pix = stg_in.clr;
        end
    end

    // odd columns take the high nibble
    always_comb begin
        res_out.byte_address   = stg_in.acc[ADDR_W:1];
        res_out.or_byte        = stg_in.xq[0] ? {pix, 4'h0} : {4'h0, pix};
        res_out.color_index    = stg_in.clr;
        res_out.bright_pattern = pi;
        res_out.red_pattern    = pr;
        res_out.green_pattern  = pg;
        res_out.blue_pattern   = pb;
    end

endmodule

// ----- hdl/rgbd_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the rgb to irgb ordered dither converter, bound to the top
// depends on rgbd_pkg and rgb_to_irgb_ordered_dither

module rgbd_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rgbd_pkg::M_DATA_W-1:0] m_tdata
);
    import rgbd_pkg::*;

    // nothing comes out in the cycle after reset
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a free receiver never blocks the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    // only one nibble of the or byte carries the pixel, and padding stays zero
    a_nibble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26:23] == 4'h0 || m_tdata[30:27] == 4'h0)
                     && m_tdata[M_DATA_W-1:99] == '0)
        else $error("bad or byte or padding");

endmodule

bind rgb_to_irgb_ordered_dither rgbd_checker u_rgbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the rgb to irgb ordered dither converter
// depends on rgbd_pkg and the rgb_to_irgb_ordered_dither top level

module tb_top;

    import rgbd_pkg::*;

    // one input pixel, packed exactly as s_tdata
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] y_pos;
        logic [11:0] x_pos;
    } pixel_t;

    localparam logic [APB_AW-1:0] ADDR_MAP_WIDTH = {REG_MAP_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_DITHER_EN = {REG_DITHER_EN, 2'b00};
    localparam int DRAIN_CYCLES = NSTG + 4;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 64;
    localparam int PHASE_ITEMS  = 100;

    // directed colors as {red, green, blue}
    localparam logic [23:0] DIRECTED_RGB [20] = '{
        24'hFFFFFF, 24'h000000, 24'h800000, 24'h008000, 24'h000080,
        24'h808080, 24'h7F7F7F, 24'h404040, 24'h7F787F, 24'h7F777F,
        24'h3F3F3F, 24'h202020, 24'h1F1F1F, 24'h7F0000, 24'h007F00,
        24'h00007F, 24'hC8C80A, 24'h0AC8C8, 24'h87FF01, 24'h3F3F38
    };

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor copy of the registers
    logic [MAPW_W-1:0]   cfg_map_width = MAP_WIDTH_RST;
    logic                cfg_dither    = DITHER_EN_RST;

    result_t             pending_results [$];
    int                  mismatches = 0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  hold_token = 0;
    int                  hold_seen  = 0;
    int                  hold_left  = 0;
    int                  quiet_cycles = 0;

    rgb_to_irgb_ordered_dither dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // bright ramp: top entry fully set
    function automatic logic [PAT_W-1:0] ramp_top_full(input int unsigned idx);
        idx = idx & 15;
        return (idx == 15) ? 16'hFFFF : RAMP[idx];
    endfunction

    // expected result of one pixel under the current registers
    function automatic result_t convert_pixel(input pixel_t p);
        int unsigned r, g, b, m, ofst;
        logic [PAT_W-1:0] pi, pr, pg, pb, d;
        logic [3:0] clr, nib;
        logic [25:0] sum;
        result_t res;
        r = p.red;
        g = p.green;
        b = p.blue;
        if (r >= g && r >= b) begin
            m = r;
        end else if (g >= b) begin
            m = g;
        end else begin
            m = b;
        end
        if (m > 127) begin
            pi  = ramp_top_full(m >> 3);
            pr  = ramp_top_full((r << 4) / (m + 8));
            pg  = ramp_top_full((g << 4) / (m + 8));
            pb  = ramp_top_full((b << 4) / (m + 8));
            clr = {1'b1, p.red[7], p.green[7], p.blue[7]};
        end else if ((m - r) + (m - g) + (m - b) < 8) begin
            if (m > 63) begin
                // light grey: intensity is the complement of the color planes
                d   = RAMP[((m - 64) >> 2) & 15];
                pi  = ~d;
                pr  = d;
                pg  = d;
                pb  = d;
                clr = 4'h7;
            end else begin
                pi  = RAMP[(m >> 2) & 15];
                pr  = '0;
                pg  = '0;
                pb  = '0;
                clr = (m > 31) ? 4'h8 : 4'h0;
            end
        end else begin
            pi  = '0;
            pr  = RAMP[(r >> 3) & 15];
            pg  = RAMP[(g >> 3) & 15];
            pb  = RAMP[(b >> 3) & 15];
            clr = {1'b0, p.red[6], p.green[6], p.blue[6]};
        end
        if (cfg_dither) begin
            ofst = 4 * p.y_pos[1:0] + p.x_pos[1:0];
            nib  = {pi[ofst], pr[ofst], pg[ofst], pb[ofst]};
        end else begin
            nib = clr;
        end
        sum = 26'(cfg_map_width) * 26'(p.y_pos) + 26'(p.x_pos);
        res.byte_address   = sum[ADDR_W:1];
        res.or_byte        = p.x_pos[0] ? {nib, 4'h0} : {4'h0, nib};
        res.color_index    = clr;
        res.bright_pattern = pi;
        res.red_pattern    = pr;
        res.green_pattern  = pg;
        res.blue_pattern   = pb;
        return res;
    endfunction

    // random pixel, biased toward each conversion case
    function automatic pixel_t random_pixel();
        pixel_t p;
        int unsigned base;
        p.x_pos = 12'($urandom);
        p.y_pos = 12'($urandom);
        case ($urandom_range(3))
            0: begin
                p.red   = 8'($urandom);
                p.green = 8'($urandom);
                p.blue  = 8'($urandom);
            end
            1: begin
                p.red   = 8'($urandom_range(128, 255));
                p.green = 8'($urandom);
                p.blue  = 8'($urandom);
            end
            2: begin
                base    = $urandom_range(0, 127);
                p.red   = 8'(base);
                p.green = 8'(base - (base < 4 ? base : $urandom_range(0, 3)));
                p.blue  = 8'(base - (base < 4 ? base : $urandom_range(0, 3)));
            end
            default: begin
                p.red   = 8'($urandom_range(0, 127));
                p.green = 8'($urandom_range(0, 127));
                p.blue  = 8'($urandom_range(0, 127));
            end
        endcase
        return p;
    endfunction

    // offer one pixel, with an optional idle gap first; records the prediction
    task automatic send_pixel(input pixel_t p);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 5);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_results.push_back(convert_pixel(p));
    endtask

    // drop valid and wait for every expected result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        if (addr == ADDR_MAP_WIDTH) begin
            cfg_map_width = data[MAPW_W-1:0];
        end else if (addr == ADDR_DITHER_EN) begin
            cfg_dither = data[0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int unsigned width, input bit dither);
        drain_results();
        write_reg(ADDR_MAP_WIDTH, width);
        write_reg(ADDR_DITHER_EN, APB_DW'(dither));
    endtask

    // every case at reset settings, positions and ties
    task automatic test_directed_cases();
        pixel_t p;
        for (int i = 0; i < 20; i++) begin
            {p.red, p.green, p.blue} = DIRECTED_RGB[i];
            p.x_pos = (i == 0) ? 12'hFFF : 12'(i * 3);
            p.y_pos = (i == 1) ? 12'hFFF : 12'(i * 5);
            send_pixel(p);
        end
    endtask

    // solid color mode at the widest map, address wrap at the far corner
    task automatic test_solid_color_extremes();
        pixel_t p;
        set_config(8191, 1'b0);
        for (int i = 0; i < 5; i++) begin
            {p.red, p.green, p.blue} = DIRECTED_RGB[i * 4 + 1];
            p.x_pos = 12'hFFF - 12'(i);
            p.y_pos = 12'hFFF;
            send_pixel(p);
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_config(16, 1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_token++;
        for (int i = 0; i < 24; i++) send_pixel(random_pixel());
    endtask

    // random pixels over several register settings and idle mixes
    task automatic test_random_phases();
        int unsigned width;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: width = 4096;
                1: width = 0;
                2: width = $urandom_range(1, 256) * 16;
                3: width = 8191;
                4: width = 16;
                default: width = $urandom_range(0, 8191);
            endcase
            set_config(width, ph[0] ? 1'b0 : 1'b1);
            if (ph < 2) begin
                tx_idle_pct = 29;
                rx_idle_pct = 48;
            end else if (ph < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(random_pixel());
        end
    endtask

    // receiver side: random stalls, plus a long hold when requested
    always @(negedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: %h", m_tdata);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.byte_address !== want.byte_address
                        || got.or_byte !== want.or_byte
                        || got.color_index !== want.color_index
                        || got.bright_pattern !== want.bright_pattern
                        || got.red_pattern !== want.red_pattern
                        || got.green_pattern !== want.green_pattern
                        || got.blue_pattern !== want.blue_pattern) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp/got: addr %h/%h or %h/%h clr %h/%h",
                                 want.byte_address, got.byte_address,
                                 want.or_byte, got.or_byte,
                                 want.color_index, got.color_index);
                        $display("  masks exp i%h r%h g%h b%h got i%h r%h g%h b%h",
                                 want.bright_pattern, want.red_pattern,
                                 want.green_pattern, want.blue_pattern,
                                 got.bright_pattern, got.red_pattern,
                                 got.green_pattern, got.blue_pattern);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 29;
        rx_idle_pct = 48;
        test_directed_cases();
        test_solid_color_extremes();
        test_backpressure();
        test_random_phases();
        drain_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
